/* hw/rtl/urgent_first_fifo_queue_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef URGENT_FIRST_FIFO_QUEUE_ASSERT_SVH
`define URGENT_FIRST_FIFO_QUEUE_ASSERT_SVH

// Check on every rising clock edge outside reset.
`define UFQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define UFQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/ufq_pkg.sv */
`timescale 1ns / 1ps

package ufq_pkg;

   // Operation codes.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_LOOKUP  = 2'd2;

   // Class codes.
   localparam logic [1:0] CLASS_HIGH = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_ENQUEUED  = 3'd0;
   localparam logic [2:0] ST_REMOVED   = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_FOUND     = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] item_id;
      logic [1:0]  item_class;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] removed_id;
      logic [1:0]  removed_class;
      logic [4:0]  occupancy;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic        enq;
      logic        deq;
      logic [15:0] item_id;
      logic [1:0]  item_class;
   } ufq_cmd_type;

   // Contents of one cell, handed to the neighbor toward the head.
   typedef struct packed {
      logic        valid;
      logic [15:0] id;
      logic [1:0]  cls;
   } ufq_slot_type;

   // Chain that runs from the head cell toward the tail.
   typedef struct packed {
      logic        valid;      // this cell holds an entry
      logic        high_seen;  // a high entry sits here or closer to the head
      logic        found;      // lookup match here or closer to the head
      logic [15:0] rem_id;
      logic [1:0]  rem_cls;
   } ufq_link_type;

endpackage

/* hw/rtl/urgent_first_fifo_queue.sv */
`timescale 1ns / 1ps

// Queue of up to DEPTH entries (16-bit identifier, 2-bit class) held in
// arrival order in a row of cells, oldest at cell 0. Enqueue appends at the
// tail or answers full. Dequeue takes the oldest high-class entry if any,
// else the oldest entry, and the cells behind it each move one place toward
// the head. Lookup answers found or not found. Every request gives exactly
// one response, registered, on the cycle after acceptance; a request is
// taken in every cycle in which the response register is empty or being
// drained, so the block sustains one request per cycle. The cycle time is
// set by the chains that run along the row of cells (first high entry,
// identifier match, removed-entry select), whose length grows with DEPTH.
// Occupancy in the response is the count after the operation, kept to its
// low five bits.

module urgent_first_fifo_queue #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ufq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ufq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                  req_accept;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  full;
   logic                  empty;
   ufq_pkg::ufq_cmd_type  cmd;
   ufq_pkg::ufq_link_type link [DEPTH+1];
   ufq_pkg::ufq_slot_type slot [DEPTH+1];
   logic                  any_high;
   logic                  rsp_valid_ff;
   ufq_pkg::rsp_type      rsp_data_ff;
   ufq_pkg::rsp_type      rsp_data_in;

   // Hold requests while a finished response is still waiting.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.enq        = req_accept & (req_data.operation == ufq_pkg::OP_ENQUEUE);
      cmd.deq        = req_accept & (req_data.operation == ufq_pkg::OP_DEQUEUE) & ~empty;
      cmd.item_id    = req_data.item_id;
      cmd.item_class = req_data.item_class;
   end

   // Head of the chain: cell 0 always has a filled neighbor in front.
   always_comb begin
      link[0].valid     = 1'b1;
      link[0].high_seen = 1'b0;
      link[0].found     = 1'b0;
      link[0].rem_id    = 16'd0;
      link[0].rem_cls   = 2'd0;
   end

   // Past the tail there is nothing to shift in.
   assign slot[DEPTH] = '0;
   assign any_high    = link[DEPTH].high_seen;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ufq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .head      ((i == 0) ? 1'b1 : 1'b0),
         .any_high  (any_high),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .next_slot (slot[i+1]),
         .slot      (slot[i])
      );
   end

   // Track the fill level alongside the cells.
   always_comb begin
      count_in = count_ff;
      if (cmd.enq && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Build the response for the request being accepted.
   always_comb begin
      rsp_data_in.status        = ufq_pkg::ST_NOT_FOUND;
      rsp_data_in.removed_id    = 16'd0;
      rsp_data_in.removed_class = 2'd0;
      rsp_data_in.occupancy     = 5'(count_in);
      unique case (req_data.operation)
         ufq_pkg::OP_ENQUEUE: begin
            rsp_data_in.status = full ? ufq_pkg::ST_FULL : ufq_pkg::ST_ENQUEUED;
         end
         ufq_pkg::OP_DEQUEUE: begin
            if (empty) begin
               rsp_data_in.status = ufq_pkg::ST_EMPTY;
            end else begin
               rsp_data_in.status        = ufq_pkg::ST_REMOVED;
               rsp_data_in.removed_id    = link[DEPTH].rem_id;
               rsp_data_in.removed_class = link[DEPTH].rem_cls;
            end
         end
         ufq_pkg::OP_LOOKUP: begin
            rsp_data_in.status = link[DEPTH].found ? ufq_pkg::ST_FOUND
                                                   : ufq_pkg::ST_NOT_FOUND;
         end
         default: begin
            rsp_data_in.status = ufq_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   // Response register: load on accept, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/ufq_cell.sv */
`timescale 1ns / 1ps

module ufq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ufq_pkg::ufq_cmd_type  cmd,
   input  logic                  head,
   input  logic                  any_high,
   input  ufq_pkg::ufq_link_type link_in,
   output ufq_pkg::ufq_link_type link_out,
   input  ufq_pkg::ufq_slot_type next_slot,
   output ufq_pkg::ufq_slot_type slot
);

   logic        valid_ff;
   logic [15:0] id_ff;
   logic [1:0]  cls_ff;

   logic own_high;
   logic high_seen_out;
   logic is_removed;
   logic shift;
   logic load;

   always_comb begin
      own_high      = valid_ff & (cls_ff == ufq_pkg::CLASS_HIGH);
      high_seen_out = link_in.high_seen | own_high;
      // The removed entry is the first high one, else the head.
      is_removed    = any_high ? (own_high & ~link_in.high_seen) : head;
      // Cells at or behind the removed entry take their neighbor's contents.
      shift         = cmd.deq & (any_high ? high_seen_out : 1'b1);
      // The first free cell takes a new entry.
      load          = cmd.enq & ~valid_ff & link_in.valid;

      link_out.valid     = valid_ff;
      link_out.high_seen = high_seen_out;
      link_out.found     = link_in.found | (valid_ff & (id_ff == cmd.item_id));
      link_out.rem_id    = link_in.rem_id | ((is_removed & valid_ff) ? id_ff : 16'd0);
      link_out.rem_cls   = link_in.rem_cls | ((is_removed & valid_ff) ? cls_ff : 2'd0);

      slot.valid = valid_ff;
      slot.id    = id_ff;
      slot.cls   = cls_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= next_slot.valid;
      end else if (load) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         id_ff  <= next_slot.id;
         cls_ff <= next_slot.cls;
      end else if (load) begin
         id_ff  <= cmd.item_id;
         cls_ff <= cmd.item_class;
      end
   end

endmodule

/* hw/rtl/ufq_checker.sv */
`timescale 1ns / 1ps

`include "urgent_first_fifo_queue_assert.svh"

module ufq_checker #(
   parameter int DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input ufq_pkg::rsp_type rsp_data
);

   `UFQ_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

   `UFQ_ASSERT(a_accept_gives_rsp, (req_valid && !req_stall) |=> rsp_valid, "accepted request gave no response")

   `UFQ_ASSERT(a_removed_fields_zero, (rsp_valid && rsp_data.status != ufq_pkg::ST_REMOVED) |-> (rsp_data.removed_id == 16'd0 && rsp_data.removed_class == 2'd0), "removed fields set without a removal")

   `UFQ_ASSERT(a_empty_has_no_entries, (rsp_valid && rsp_data.status == ufq_pkg::ST_EMPTY) |-> (rsp_data.occupancy == 5'd0), "empty status with entries held")

   `UFQ_ASSERT(a_full_at_depth, (rsp_valid && rsp_data.status == ufq_pkg::ST_FULL) |-> (rsp_data.occupancy == 5'(DEPTH)), "full status below depth")

endmodule

bind urgent_first_fifo_queue ufq_checker #(.DEPTH(DEPTH)) u_ufq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH           = 16;
   localparam int ITEMS_PER_PHASE = 270;
   localparam int TIDE_LENGTH     = 40;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DIRECTED_COUNT  = 25;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [1:0] CLASS_LOW    = 2'd0;
   localparam logic [1:0] CLASS_NORMAL = 2'd1;
   localparam logic [1:0] CLASS_THREE  = 2'd3;

   // One directed row: the request and, where it is plain to see, the response.
   typedef struct packed {
      ufq_pkg::req_type req;
      logic             typed;
      ufq_pkg::rsp_type resp;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] id;
      logic [1:0]  cls;
   } held_entry_type;

   localparam ufq_pkg::rsp_type NO_RSP = '0;

   // Empty-state probes, a fill to the top with extreme and duplicate ids and
   // every class code, a rejected enqueue, then lookups and urgent-first removals.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      {ufq_pkg::OP_DEQUEUE, 16'h0000, CLASS_LOW,    1'b1,
       ufq_pkg::ST_EMPTY,     16'h0000, CLASS_LOW, 5'd0},
      {ufq_pkg::OP_LOOKUP,  16'hFFFF, CLASS_LOW,    1'b1,
       ufq_pkg::ST_NOT_FOUND, 16'h0000, CLASS_LOW, 5'd0},
      {OP_UNUSED,           16'h5A5A, CLASS_THREE,  1'b1,
       ufq_pkg::ST_NOT_FOUND, 16'h0000, CLASS_LOW, 5'd0},
      {ufq_pkg::OP_ENQUEUE, 16'hFFFF, CLASS_LOW,    1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd1},
      {ufq_pkg::OP_ENQUEUE, 16'h0000, CLASS_THREE,  1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd2},
      {ufq_pkg::OP_ENQUEUE, 16'h0001, CLASS_NORMAL, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd3},
      {ufq_pkg::OP_ENQUEUE, 16'h8000, ufq_pkg::CLASS_HIGH, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd4},
      {ufq_pkg::OP_ENQUEUE, 16'h1234, CLASS_NORMAL, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd5},
      {ufq_pkg::OP_ENQUEUE, 16'h1234, CLASS_LOW,    1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd6},
      {ufq_pkg::OP_ENQUEUE, 16'h00FF, ufq_pkg::CLASS_HIGH, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd7},
      {ufq_pkg::OP_ENQUEUE, 16'hFF00, CLASS_THREE,  1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd8},
      {ufq_pkg::OP_ENQUEUE, 16'hAAAA, CLASS_NORMAL, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd9},
      {ufq_pkg::OP_ENQUEUE, 16'h5555, CLASS_LOW,    1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd10},
      {ufq_pkg::OP_ENQUEUE, 16'h8000, ufq_pkg::CLASS_HIGH, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd11},
      {ufq_pkg::OP_ENQUEUE, 16'h7FFE, CLASS_NORMAL, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd12},
      {ufq_pkg::OP_ENQUEUE, 16'h0F0F, CLASS_LOW,    1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd13},
      {ufq_pkg::OP_ENQUEUE, 16'hF0F0, ufq_pkg::CLASS_HIGH, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd14},
      {ufq_pkg::OP_ENQUEUE, 16'h3C3C, CLASS_NORMAL, 1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd15},
      {ufq_pkg::OP_ENQUEUE, 16'hC3C3, CLASS_THREE,  1'b1,
       ufq_pkg::ST_ENQUEUED,  16'h0000, CLASS_LOW, 5'd16},
      {ufq_pkg::OP_ENQUEUE, 16'hBEEF, ufq_pkg::CLASS_HIGH, 1'b1,
       ufq_pkg::ST_FULL,      16'h0000, CLASS_LOW, 5'd16},
      {ufq_pkg::OP_LOOKUP,  16'h8000, CLASS_LOW,    1'b0, NO_RSP},
      {ufq_pkg::OP_LOOKUP,  16'h7FFF, ufq_pkg::CLASS_HIGH, 1'b0, NO_RSP},
      {ufq_pkg::OP_DEQUEUE, 16'hFFFF, CLASS_THREE,  1'b0, NO_RSP},
      {OP_UNUSED,           16'h0000, CLASS_LOW,    1'b0, NO_RSP},
      {ufq_pkg::OP_DEQUEUE, 16'h0000, CLASS_LOW,    1'b0, NO_RSP}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   ufq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ufq_pkg::rsp_type rsp_data;

   // Shadow of the queue contents, oldest first, and the responses still owed.
   held_entry_type   held_entries[$];
   ufq_pkg::rsp_type pending_responses[$];
   ufq_pkg::rsp_type oldest_pending;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_asks;
   int hold_off_taken;
   int hold_off_left;
   int mismatch_count;

   urgent_first_fifo_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one request to the shadow queue and return the response it earns.
   function automatic ufq_pkg::rsp_type predict_response(input ufq_pkg::req_type r);
      ufq_pkg::rsp_type res;
      held_entry_type   entry;
      int               pos;
      bit               got;
      res = '0;
      res.status = ufq_pkg::ST_NOT_FOUND;
      pos = 0;
      got = 1'b0;
      case (r.operation)
         ufq_pkg::OP_ENQUEUE: begin
            if (held_entries.size() >= DEPTH) begin
               res.status = ufq_pkg::ST_FULL;
            end else begin
               entry.id  = r.item_id;
               entry.cls = r.item_class;
               held_entries.push_back(entry);
               res.status = ufq_pkg::ST_ENQUEUED;
            end
         end
         ufq_pkg::OP_DEQUEUE: begin
            if (held_entries.size() == 0) begin
               res.status = ufq_pkg::ST_EMPTY;
            end else begin
               // Take the oldest high entry; fall back to the head.
               foreach (held_entries[i]) begin
                  if (!got && held_entries[i].cls == ufq_pkg::CLASS_HIGH) begin
                     pos = i;
                     got = 1'b1;
                  end
               end
               res.removed_id    = held_entries[pos].id;
               res.removed_class = held_entries[pos].cls;
               held_entries.delete(pos);
               res.status = ufq_pkg::ST_REMOVED;
            end
         end
         ufq_pkg::OP_LOOKUP: begin
            foreach (held_entries[i]) begin
               if (held_entries[i].id == r.item_id) res.status = ufq_pkg::ST_FOUND;
            end
         end
         default: ;
      endcase
      res.occupancy = 5'(held_entries.size());
      return res;
   endfunction

   // Draw a request; fill_pct leans the mix toward enqueue (high) or dequeue (low)
   // so the queue swings between empty and full.
   function automatic ufq_pkg::req_type random_request(input int fill_pct);
      ufq_pkg::req_type r;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         r.operation = OP_UNUSED;
      end else if (pick < 22) begin
         r.operation = ufq_pkg::OP_LOOKUP;
      end else if ($urandom_range(0, 99) < fill_pct) begin
         r.operation = ufq_pkg::OP_ENQUEUE;
      end else begin
         r.operation = ufq_pkg::OP_DEQUEUE;
      end
      // Reuse held ids often so lookups hit and duplicates appear.
      pick = $urandom_range(0, 2);
      if (pick == 0 && held_entries.size() > 0) begin
         r.item_id = held_entries[$urandom_range(0, held_entries.size() - 1)].id;
      end else if (pick == 1) begin
         r.item_id = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) :
                     16'hFFFF - 16'($urandom_range(0, 15));
      end else begin
         r.item_id = 16'($urandom());
      end
      r.item_class = ($urandom_range(0, 3) == 0) ? ufq_pkg::CLASS_HIGH
                                                 : 2'($urandom_range(0, 3));
      return r;
   endfunction

   // Present one request from a falling edge, with random idle gaps, and hold
   // it until accepted. Owe either the typed response or the predicted one.
   task automatic offer(input ufq_pkg::req_type r, input logic typed,
                        input ufq_pkg::rsp_type typed_rsp);
      ufq_pkg::rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = predict_response(r);
      pending_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      hold_off_taken = 0;
      hold_off_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_asks != hold_off_taken) begin
            hold_off_left  = HOLD_OFF_CYCLES;
            hold_off_taken = hold_off_asks;
         end
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // Check every accepted response against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: response with nothing owed: %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            oldest_pending = pending_responses.pop_front();
            if (rsp_data.status !== oldest_pending.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        oldest_pending.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.removed_id !== oldest_pending.removed_id) begin
               $display("%0t: removed_id expected %h actual %h", $time,
                        oldest_pending.removed_id, rsp_data.removed_id);
               mismatch_count++;
            end
            if (rsp_data.removed_class !== oldest_pending.removed_class) begin
               $display("%0t: removed_class expected %0d actual %0d", $time,
                        oldest_pending.removed_class, rsp_data.removed_class);
               mismatch_count++;
            end
            if (rsp_data.occupancy !== oldest_pending.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d", $time,
                        oldest_pending.occupancy, rsp_data.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int fill_pct;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      hold_off_asks  = 0;
      mismatch_count = 0;
      send_idle_pct  = 25;
      recv_stall_pct = 49;
      fill_pct       = 30;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         offer(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].resp);
      end

      // Random phases: sender-light idling, receiver-light idling, then none.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
         recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 25 : 0;
         // Hold off the receiver while requests keep coming back to back.
         if (phase == 2) hold_off_asks++;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k % TIDE_LENGTH == 0) fill_pct = (fill_pct == 70) ? 30 : 70;
            offer(random_request(fill_pct), 1'b0, NO_RSP);
         end
         // Pause the sender until everything owed has returned.
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
